/* rtl/mafhp_pkg.sv */
// Shared types, codes and lookup functions for the MPEG audio frame header parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mafhp_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MORE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Stream widths (fields packed low to high, padded to whole bytes)
  localparam int IN_W  = 48;
  localparam int OUT_W = 48;

  // Header version codes
  localparam logic [1:0] VER_25  = 2'd0;
  localparam logic [1:0] VER_RSV = 2'd1;
  localparam logic [1:0] VER_2   = 2'd2;
  localparam logic [1:0] VER_1   = 2'd3;

  // Sample-rate index codes
  localparam logic [1:0] SRI_44K = 2'd0;
  localparam logic [1:0] SRI_48K = 2'd1;
  localparam logic [1:0] SRI_32K = 2'd2;
  localparam logic [1:0] SRI_RSV = 2'd3;

  // Division by the MPEG-1 base rate after the 1000 factor cancels:
  //   1000/44100 = 10/441, 1000/48000 = 1/(16*3), 1000/32000 = 1/32.
  // Quotient estimate = (y * recip) >> 32, one short at most, then corrected.
  localparam logic [8:0]  DIV_441   = 9'd441;
  localparam logic [8:0]  DIV_3     = 9'd3;
  localparam logic [8:0]  DIV_32    = 9'd32;
  localparam logic [30:0] RECIP_441 = 31'd9739154;
  localparam logic [30:0] RECIP_3   = 31'd1431655765;
  localparam logic [30:0] RECIP_32  = 31'd134217728;

  // One classified header travelling from front to back
  typedef struct packed {
    logic [1:0]  pre_status;  // ST_OK means "still a candidate"
    logic [19:0] dividend;
    logic [30:0] recip;
    logic [8:0]  divisor;
    logic        pad;
    logic        layer1;
    logic [1:0]  layer;
    logic [10:0] spf;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [15:0] avail;
  } hdr_item_t;

  localparam logic [0:15][8:0] KBPS_V1_L1 = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [0:15][8:0] KBPS_V1_L2 = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [0:15][8:0] KBPS_V1_L3 = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [0:15][8:0] KBPS_V2_L1 = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [0:15][8:0] KBPS_V2_L23 = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Bitrate in kbit/s
  function automatic logic [8:0] kbps_lookup(input logic m1, input logic [1:0] lyr,
                                             input logic [3:0] idx);
    logic [8:0] v;
    v = '0;
    unique case ({m1, lyr})
      3'b101:  v = KBPS_V1_L1[idx];
      3'b110:  v = KBPS_V1_L2[idx];
      3'b111:  v = KBPS_V1_L3[idx];
      3'b001:  v = KBPS_V2_L1[idx];
      3'b010,
      3'b011:  v = KBPS_V2_L23[idx];
      default: v = '0;
    endcase
    return v;
  endfunction

  // MPEG-1 base rate in Hz for a rate index
  function automatic logic [15:0] base_rate(input logic [1:0] sri);
    logic [15:0] v;
    v = '0;
    unique case (sri)
      SRI_44K: v = 16'd44100;
      SRI_48K: v = 16'd48000;
      SRI_32K: v = 16'd32000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/mafhp_front.sv */
// Front end: accepts header requests, checks sync and reserved codes, looks up
// bitrate and rate, and forms the dividend for the back end. Uses mafhp_pkg.
`default_nettype none

module mafhp_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [mafhp_pkg::IN_W-1:0] s_tdata,
  output logic                         item_valid,
  input  wire logic                    item_ready,
  output mafhp_pkg::hdr_item_t         item
);
  import mafhp_pkg::*;

  logic [31:0] hw;
  logic [15:0] avail;
  logic [7:0]  b0, b1, b2, b3;
  logic [1:0]  ver, lay, sri, lyr, shamt;
  logic [3:0]  bri;
  logic        m1, reserved, sync_ok;
  logic [8:0]  kbps;
  logic [7:0]  coef;
  logic [16:0] kprod, xval;
  logic [19:0] x10;
  hdr_item_t   cls;
  logic        fv;
  hdr_item_t   fitem;

  assign hw    = s_tdata[31:0];
  assign avail = s_tdata[47:32];
  assign b0 = hw[31:24];
  assign b1 = hw[23:16];
  assign b2 = hw[15:8];
  assign b3 = hw[7:0];
  assign ver = b1[4:3];
  assign lay = b1[2:1];
  assign bri = b2[7:4];
  assign sri = b2[3:2];

  always_comb begin
    sync_ok  = (b0 == 8'hFF) && (b1[7:5] == 3'b111);
    reserved = (ver == VER_RSV) || (lay == 2'd0) || (bri == 4'd0) || (bri == 4'd15) ||
               (sri == SRI_RSV);
    m1   = (ver == VER_1);
    lyr  = 2'(3'd4 - {1'b0, lay});
    kbps = kbps_lookup(m1, lyr, bri);
    // rate = base >> shamt, so br/sr = kbps*1000*2^shamt/base
    case (ver)
      VER_1:   shamt = 2'd0;
      VER_2:   shamt = 2'd1;
      default: shamt = 2'd2;
    endcase
    if (lyr == 2'd1)              coef = 8'd12;
    else if (lyr == 2'd2 || m1)   coef = 8'd144;
    else                          coef = 8'd72;
    kprod = 17'(coef * kbps);
    xval  = 17'(kprod << shamt);
    x10   = 20'({xval, 3'b000}) + 20'({xval, 1'b0});

    cls.pad    = b2[1];
    cls.layer  = lyr;
    cls.layer1 = (lyr == 2'd1);
    if (lyr == 2'd1)    cls.spf = 11'd384;
    else if (lyr == 2'd2 || m1) cls.spf = 11'd1152;
    else                cls.spf = 11'd576;
    cls.rate  = base_rate(sri) >> shamt;
    cls.chans = (b3[7:6] == 2'b11) ? 2'd1 : 2'd2;
    cls.avail = avail;
    case (sri)
      SRI_44K: begin
        cls.dividend = x10;
        cls.recip    = RECIP_441;
        cls.divisor  = DIV_441;
      end
      SRI_48K: begin
        cls.dividend = 20'(xval >> 4);
        cls.recip    = RECIP_3;
        cls.divisor  = DIV_3;
      end
      default: begin
        cls.dividend = 20'(xval);
        cls.recip    = RECIP_32;
        cls.divisor  = DIV_32;
      end
    endcase
    if (avail < 16'd4)             cls.pre_status = ST_MORE;
    else if (!sync_ok || reserved) cls.pre_status = ST_BAD;
    else                           cls.pre_status = ST_OK;
  end

  // Single holding register; refills in the same cycle it drains
  assign s_tready   = !fv || item_ready;
  assign item_valid = fv;
  assign item       = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fitem <= cls;
    end
  end

endmodule

`default_nettype wire

/* rtl/mafhp_queue.sv */
// Short FIFO of classified headers between front and back end.
// Uses mafhp_pkg for the item type.
`default_nettype none

module mafhp_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   not_full,
  input  wire mafhp_pkg::hdr_item_t wr_item,
  input  wire logic              pop,
  output logic                   not_empty,
  output mafhp_pkg::hdr_item_t   rd_item
);
  import mafhp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdr_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/mafhp_back.sv */
// Back end: reciprocal-multiply division, frame length and final checks,
// three stages ending in the output register. Uses mafhp_pkg.
`default_nettype none

module mafhp_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire mafhp_pkg::hdr_item_t     item,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [mafhp_pkg::OUT_W-1:0]   m_tdata
);
  import mafhp_pkg::*;

  logic        adv;
  logic        v1, v2, v3;
  hdr_item_t   it1, it2;
  logic [50:0] prod1;
  logic [11:0] quot2;

  logic [11:0] q0, quot, qsum, flen;
  logic [20:0] qd;
  logic [19:0] rem;

  logic [1:0]  o_status, o_chans, o_layer;
  logic [11:0] o_len;
  logic [10:0] o_spf;
  logic [15:0] o_rate;
  logic [1:0]  n_status, n_chans, n_layer;
  logic [11:0] n_len;
  logic [10:0] n_spf;
  logic [15:0] n_rate;

  // Whole pipe moves when the output register is free or being drained
  assign adv        = !v3 || m_tready;
  assign item_ready = adv;

  // Stage 2: correct the quotient estimate (one short at most)
  always_comb begin
    q0   = prod1[43:32];
    qd   = 21'(q0 * it1.divisor);
    rem  = it1.dividend - 20'(qd);
    quot = (rem >= {11'd0, it1.divisor}) ? q0 + 12'd1 : q0;
  end

  // Stage 3: frame length and final status
  always_comb begin
    qsum = quot2 + {11'd0, it2.pad};
    flen = it2.layer1 ? {qsum[9:0], 2'b00} : qsum;
    n_status = ST_OK;
    n_len    = '0;
    n_spf    = '0;
    n_rate   = '0;
    n_chans  = '0;
    n_layer  = '0;
    if (it2.pre_status != ST_OK) begin
      n_status = it2.pre_status;
    end else if (flen < 12'd4) begin
      n_status = ST_BAD;
    end else if (it2.avail < {4'd0, flen}) begin
      n_status = ST_MORE;
    end else begin
      n_len   = flen;
      n_spf   = it2.spf;
      n_rate  = it2.rate;
      n_chans = it2.chans;
      n_layer = it2.layer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1      <= item;
      prod1    <= 51'(item.dividend * item.recip);
      it2      <= it1;
      quot2    <= quot;
      o_status <= n_status;
      o_len    <= n_len;
      o_spf    <= n_spf;
      o_rate   <= n_rate;
      o_chans  <= n_chans;
      o_layer  <= n_layer;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {3'b000, o_layer, o_chans, o_rate, o_spf, o_len, o_status};

endmodule

`default_nettype wire

/* rtl/mpeg_audio_frame_header_parser_core.sv */
// MPEG audio frame header parser (MPEG-1/2/2.5, layers I-III), top level.
// Path: front holding register, queue, then the back-end pipe ending in the output register.
// Throughput: one header per cycle while m_tready does not hold the output; set by the single-issue back-end pipeline.
// No state is kept between headers; results come out in input order.
// Reset: synchronous, active-high rst empties front register, queue and back pipe.
// Depends on mafhp_pkg, mafhp_front, mafhp_queue, mafhp_back.
`default_nettype none

module mpeg_audio_frame_header_parser_core #(
  parameter int QUEUE_DEPTH = 2  // entries between front and back, 2 or more
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input request: header_word [31:0], available_bytes [47:32]
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mafhp_pkg::IN_W-1:0]    s_tdata,
  // Result: status [1:0], frame_bytes [13:2], samples_per_frame [24:14],
  // sample_rate_hz [40:25], channel_count [42:41], layer_number [44:43],
  // zero fill [47:45]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mafhp_pkg::OUT_W-1:0]        m_tdata
);
  import mafhp_pkg::*;

  // Front -> queue
  logic      f_valid, f_ready;
  hdr_item_t f_item;
  // Queue -> back
  logic      q_valid, q_ready;
  hdr_item_t q_item;

  // Front: sync/reserved checks, table lookups, dividend and reciprocal select
  mafhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Decoupling queue: front keeps accepting while the back end is stalled, until the queue fills
  mafhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .not_full  (f_ready),
    .wr_item   (f_item),
    .pop       (q_ready),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  // Back: quotient by reciprocal multiply, length, availability check, output reg
  mafhp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire
